FILE: rtl/srs_pkg.sv
package srs_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int COUNT_WIDTH = 8;

	// fixed field widths
	localparam int MODE_W = 2;
	localparam int IDX_W  = 6;
	localparam int REP_W  = 8;
	localparam int LB_W   = 6;
	localparam int LC_W   = 8;
	localparam int CFG_W  = 7;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);

	// shared ALU operand width: widest operand plus a borrow bit
	localparam int DATA_W = (REP_W > COUNT_WIDTH)
		? ((REP_W > ROWS_W) ? REP_W : ROWS_W)
		: ((COUNT_WIDTH > ROWS_W) ? COUNT_WIDTH : ROWS_W);
	localparam int ALU_W  = DATA_W + 1;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADV   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN   = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  entry_index;
		logic [REP_W-1:0]  entry_repeats;
		logic [LB_W-1:0]   entry_loop_back;
		logic [LC_W-1:0]   entry_loop_count;
		logic              entry_loop_infinite;
		logic [IDX_W-1:0]  current_row;
		logic [REP_W-1:0]  current_repeat;
	} in_t;

	typedef struct packed {
		logic             position_valid;
		logic [IDX_W-1:0] next_row;
		logic [REP_W-1:0] next_repeat;
	} out_t;

	typedef struct packed {
		logic [REP_W-1:0] repeats;
		logic [LB_W-1:0]  loop_back;
		logic [LC_W-1:0]  loop_count;
		logic             infinite;
	} row_t;

endpackage

FILE: rtl/song_row_sequencer_top.sv
// Channel | Signals                           | Beat taken when
// --------+-----------------------------------+---------------------------
// input   | in_valid, in_ready, in_data       | in_valid & in_ready
// output  | out_valid, out_ready, out_data    | out_valid & out_ready
// config  | cfg_we, cfg_idx, cfg_wdata        | cfg_we (no handshake)
//
// Sequencing: one beat at a time. Load, clear and unused modes go straight
//   to the output state; an advance passes the states of the branch that
//   resolves it, with every compare on the single add/subtract unit.
// Reset: clears control, config and the per-row counter valid bits; the
//   row table is undefined until loaded.
// Stalls: a finished result parks in the output register; the sequencer
//   waits in its output state only if that register is still occupied.
module song_row_sequencer_top
	import srs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ROW  = 4'd1; // row < rows ?
	localparam logic [3:0] S_INC  = 4'd2; // rep + 1
	localparam logic [3:0] S_REP  = 4'd3; // rep + 1 < wanted ?
	localparam logic [3:0] S_LOOP = 4'd4; // counter < loop count ?
	localparam logic [3:0] S_CINC = 4'd5; // counter + 1
	localparam logic [3:0] S_BACK = 4'd6; // row - loop_back, clamped
	localparam logic [3:0] S_NEXT = 4'd7; // row + 1
	localparam logic [3:0] S_END  = 4'd8; // row + 1 >= rows ?
	localparam logic [3:0] S_OUT  = 4'd9; // park result

	logic [3:0]             state_q;
	logic [ROWS_W-1:0]      rows_q;
	logic                   loop_en_q;
	in_t                    item_q;
	out_t                   res_q;
	out_t                   out_q;
	logic                   out_valid_q;
	logic [ALU_W-1:0]       tmp_q;

	// row table: one write port at accept, registered read at accept
	row_t                   tbl_mem [MAX_ROWS];
	row_t                   tbl_rd_q;

	// loop counters: memory plus one valid bit per row; a clear resets the bits
	logic [COUNT_WIDTH-1:0] cnt_mem [MAX_ROWS];
	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic                   cnt_hit_q;
	logic [MAX_ROWS-1:0]    cnt_vld_q;

	logic                   accept;
	logic                   out_free;
	logic [ROW_W-1:0]       cur_addr;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic [REP_W-1:0]       wanted;
	logic [LC_W-1:0]        lc_eff;
	logic                   cnt_we;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic                   cnt_clr;

	// shared add/subtract unit
	logic [ALU_W-1:0]       alu_a;
	logic [ALU_W-1:0]       alu_b;
	logic                   alu_sub;
	logic [ALU_W-1:0]       alu_y;
	logic                   alu_lt;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cur_addr = ROW_W'(item_q.current_row);
	assign cnt_cur  = cnt_hit_q ? cnt_rd_q : '0;
	assign wanted   = (tbl_rd_q.repeats == '0) ? REP_W'(1) : tbl_rd_q.repeats;
	assign lc_eff   = (tbl_rd_q.loop_count == '0) ? LC_W'(1) : tbl_rd_q.loop_count;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_ROW: begin
				alu_a = ALU_W'(item_q.current_row);
				alu_b = ALU_W'(rows_q);
			end
			S_INC: begin
				alu_a   = ALU_W'(item_q.current_repeat);
				alu_b   = ALU_W'(1);
				alu_sub = 1'b0;
			end
			S_REP: begin
				alu_a = tmp_q;
				alu_b = ALU_W'(wanted);
			end
			S_LOOP: begin
				alu_a = ALU_W'(cnt_cur);
				alu_b = ALU_W'(lc_eff);
			end
			S_CINC: begin
				alu_a   = ALU_W'(cnt_cur);
				alu_b   = ALU_W'(1);
				alu_sub = 1'b0;
			end
			S_BACK: begin
				alu_a = ALU_W'(item_q.current_row);
				alu_b = ALU_W'(tbl_rd_q.loop_back);
			end
			S_NEXT: begin
				alu_a   = ALU_W'(item_q.current_row);
				alu_b   = ALU_W'(1);
				alu_sub = 1'b0;
			end
			S_END: begin
				alu_a = tmp_q;
				alu_b = ALU_W'(rows_q);
			end
			default: begin
				alu_a = '0;
			end
		endcase
		alu_y  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
		// top bit is the borrow; rep + 1 may set it but is then >= wanted
		alu_lt = alu_y[ALU_W-1];
	end

	// counter port control
	always_comb begin
		cnt_we    = 1'b0;
		cnt_wdata = '0;
		cnt_clr   = 1'b0;
		if (accept && in_data.mode == MODE_CLEAR) begin
			cnt_clr = 1'b1;
		end
		if (state_q == S_CINC) begin
			cnt_we    = 1'b1;
			cnt_wdata = COUNT_WIDTH'(alu_y);
		end
		if (state_q == S_LOOP && !tbl_rd_q.infinite && !alu_lt) begin
			// loop used up: rearm it
			cnt_we = 1'b1;
		end
		if (state_q == S_END && !alu_lt && loop_en_q) begin
			cnt_clr = 1'b1; // wrap to the first row
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= '0;
			loop_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROW_COUNT: begin
					if (32'(cfg_wdata) > MAX_ROWS) begin
						rows_q <= ROWS_W'(MAX_ROWS);
					end else begin
						rows_q <= ROWS_W'(cfg_wdata);
					end
				end
				REG_LOOP_EN: begin
					loop_en_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (accept && in_data.mode == MODE_LOAD && 32'(in_data.entry_index) < MAX_ROWS) begin
			tbl_mem[ROW_W'(in_data.entry_index)] <= '{
				repeats:    in_data.entry_repeats,
				loop_back:  in_data.entry_loop_back,
				loop_count: in_data.entry_loop_count,
				infinite:   in_data.entry_loop_infinite
			};
		end
		if (accept) begin
			tbl_rd_q <= tbl_mem[ROW_W'(in_data.current_row)];
			cnt_rd_q <= cnt_mem[ROW_W'(in_data.current_row)];
		end
		if (cnt_we) begin
			cnt_mem[cur_addr] <= cnt_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			cnt_hit_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_hit_q <= cnt_vld_q[ROW_W'(in_data.current_row)];
			end
			if (cnt_clr) begin
				cnt_vld_q <= '0;
			end else if (cnt_we) begin
				cnt_vld_q[cur_addr] <= 1'b1;
			end
		end
	end

	// item and scratch registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == S_INC || state_q == S_NEXT) begin
			tmp_q <= alu_y;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						if (in_data.mode == MODE_ADV) begin
							state_q <= S_ROW;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_ROW: begin
					state_q <= alu_lt ? S_INC : S_OUT;
				end
				S_INC: begin
					state_q <= S_REP;
				end
				S_REP: begin
					if (alu_lt) begin
						res_q   <= '{1'b1, item_q.current_row, REP_W'(tmp_q)};
						state_q <= S_OUT;
					end else if (tbl_rd_q.loop_back != '0) begin
						state_q <= S_LOOP;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_LOOP: begin
					if (tbl_rd_q.infinite) begin
						state_q <= S_BACK;
					end else if (alu_lt) begin
						state_q <= (&cnt_cur) ? S_BACK : S_CINC;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_CINC: begin
					state_q <= S_BACK;
				end
				S_BACK: begin
					// clamp the jump at the first row
					res_q.position_valid <= 1'b1;
					res_q.next_row       <= alu_lt ? '0 : IDX_W'(alu_y);
					res_q.next_repeat    <= '0;
					state_q              <= S_OUT;
				end
				S_NEXT: begin
					state_q <= S_END;
				end
				S_END: begin
					if (!alu_lt) begin
						// past the last row: wrap or end the song
						res_q <= '{loop_en_q, '0, '0};
					end else begin
						res_q <= '{1'b1, IDX_W'(tmp_q), '0};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q <= res_q;
		end
	end

	// checks
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("new beat taken while an item is in flight");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (out_valid && in_ready))
		else $error("finished result not moved to output register");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.position_valid) |->
		(out_data.next_row == '0 && out_data.next_repeat == '0))
		else $error("invalid position carries nonzero fields");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.mode == MODE_CLEAR) |=> (cnt_vld_q == '0))
		else $error("loop counters not cleared");

	a_cnt_write_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (item_q.mode == MODE_ADV && !in_ready))
		else $error("counter written outside an advance");

endmodule

FILE: dv/tb_top.sv
module tb_top
	import srs_pkg::*;
();

	// Mode 3 has no name in the package; the block must answer it with an
	// all-zero beat and leave its state alone.
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;

	localparam int STEP_BEAT = 0;
	localparam int STEP_CFG  = 1;
	localparam int PLAN_N    = 25;
	localparam int SEG_N     = 9;
	localparam int SEG_BEATS = 120;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	song_row_sequencer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Percent of cycles each side holds off.
	int send_idle;
	int recv_idle;

	// Shadow of the sequencer: row table, per-row jump counters, registers.
	row_t                   song_rows [MAX_ROWS];
	logic [COUNT_WIDTH-1:0] jump_count [MAX_ROWS];
	logic [CFG_W-1:0]       seq_rows;
	logic                   wrap_on;

	// Next positions still owed by the block, oldest first.
	out_t next_pos_q [$];
	out_t due;
	int   fault_count;

	// Playhead of the song being walked by the random part.
	int ph_row;
	int ph_rep;
	int live_rows;

	// Directed plan. Columns:
	//   kind, mode, index, repeats, loop_back, loop_count, infinite,
	//   row, repeat, typed, valid, next_row, next_repeat
	// Config rows put the row count in the mode column and the loop flag
	// in the index column. Rows with typed = 0 are checked against the
	// shadow model.
	int plan [PLAN_N][13] = '{
		// empty arrangement right after reset
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0,  0,   0, 1, 0,  0, 0},
		// unused mode, every field at its top
		'{STEP_BEAT, MODE_NONE,  63, 255, 63, 255, 1, 63, 255, 1, 0,  0, 0},
		// zero repeats, no loop on row 0
		'{STEP_BEAT, MODE_LOAD,   0,   0,  0,   0, 0, 63, 255, 1, 0,  0, 0},
		// last row: full repeats, infinite jump back to row 0
		'{STEP_BEAT, MODE_LOAD,  63, 255, 63, 255, 1,  0,   0, 1, 0,  0, 0},
		// row count above the table size clamps to 64
		'{STEP_CFG,  127,         1,   0,  0,   0, 0,  0,   0, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0,  0,   0, 1, 1,  1, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 63, 254, 1, 1,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 63,   0, 0, 0,  0, 0},
		// zero loop count acts as one jump
		'{STEP_BEAT, MODE_LOAD,  10,   2,  3,   0, 0,  0,   0, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 10,   1, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 10,   1, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 10,   1, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_CLEAR,  0,   0,  0,   0, 0,  0,   0, 1, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 10,   1, 0, 0,  0, 0},
		// jump back clamps at row 0
		'{STEP_BEAT, MODE_LOAD,   2,   1,  5, 255, 0,  0,   0, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0,  2,   0, 0, 0,  0, 0},
		// repeat index past the row's count
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 63, 255, 1, 1,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0,  0, 255, 0, 0,  0, 0},
		// one row, looping: wrap clears the counters
		'{STEP_CFG,  1,           1,   0,  0,   0, 0,  0,   0, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0,  0,   0, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0,  1,   0, 1, 0,  0, 0},
		// row 10 is last, no looping: song ends after its jump
		'{STEP_CFG,  11,          0,   0,  0,   0, 0,  0,   0, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 10,   1, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 10,   1, 0, 0,  0, 0},
		'{STEP_BEAT, MODE_ADV,    0,   0,  0,   0, 0, 11,   0, 1, 0,  0, 0}
	};

	// Random phases sweep the register space, extremes included.
	logic [CFG_W-1:0] seg_rows [SEG_N] = '{7'd127, 7'd5, 7'd64, 7'd1, 7'd33, 7'd0,
		7'd64, 7'd12, 7'd3};
	logic             seg_wrap [SEG_N] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b1};

	function automatic void wipe_jumps();
		foreach (jump_count[i])
			jump_count[i] = '0;
	endfunction

	// Applies one beat to the shadow state and returns the next position.
	function automatic out_t advance_song(in_t it);
		out_t r;
		row_t e;
		int   rows, row, rep, wanted, lc, back;
		r = '0;
		if (it.mode == MODE_LOAD) begin
			song_rows[it.entry_index].repeats    = it.entry_repeats;
			song_rows[it.entry_index].loop_back  = it.entry_loop_back;
			song_rows[it.entry_index].loop_count = it.entry_loop_count;
			song_rows[it.entry_index].infinite   = it.entry_loop_infinite;
			return r;
		end
		if (it.mode == MODE_CLEAR) begin
			wipe_jumps();
			return r;
		end
		if (it.mode != MODE_ADV)
			return r;

		rows = (int'(seq_rows) > MAX_ROWS) ? MAX_ROWS : int'(seq_rows);
		row  = int'(it.current_row);
		rep  = int'(it.current_repeat);
		if (rows == 0 || row >= rows)
			return r;

		e = song_rows[row];
		wanted = (e.repeats == '0) ? 1 : int'(e.repeats);
		r.position_valid = 1'b1;
		if (rep + 1 < wanted) begin
			r.next_row    = it.current_row;
			r.next_repeat = REP_W'(rep + 1);
			return r;
		end

		if (e.loop_back != '0) begin
			lc   = (e.loop_count == '0) ? 1 : int'(e.loop_count);
			back = int'(e.loop_back);
			if (e.infinite || int'(jump_count[row]) < lc) begin
				if (!e.infinite && int'(jump_count[row]) < COUNT_MAX)
					jump_count[row] = jump_count[row] + 1'b1;
				r.next_row = (row > back) ? IDX_W'(row - back) : '0;
				return r;
			end
			jump_count[row] = '0;
		end

		if (row + 1 >= rows) begin
			if (!wrap_on)
				return '0;
			wipe_jumps();
			return r;
		end
		r.next_row = IDX_W'(row + 1);
		return r;
	endfunction

	function automatic in_t noise_item();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(in_t)-1:0];
	endfunction

	// Mostly short rows with short loops, so jumps, exits and wraps come often.
	function automatic in_t shaped_load();
		in_t it;
		int  pick;
		it = noise_item();
		it.mode = MODE_LOAD;
		pick = $urandom_range(0, 9);
		it.entry_repeats = (pick < 7) ? REP_W'($urandom_range(0, 3))
			: REP_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 9);
		it.entry_loop_back = (pick < 6) ? '0
			: (pick < 9) ? LB_W'($urandom_range(1, 4)) : LB_W'($urandom_range(0, 63));
		pick = $urandom_range(0, 9);
		it.entry_loop_count = (pick < 7) ? LC_W'($urandom_range(0, 3))
			: LC_W'($urandom_range(0, 255));
		it.entry_loop_infinite = ($urandom_range(0, 9) == 0);
		return it;
	endfunction

	// One beat on the input channel. Starts and ends at a falling edge.
	task automatic play_beat(input in_t it, input bit typed, input out_t want,
		output out_t pos);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		pos = advance_song(it);
		next_pos_q.insert(next_pos_q.size(), typed ? want : pos);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed beat has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (next_pos_q.size() != 0);
	endtask

	// Both registers, back to back; block must be idle.
	task automatic write_regs(input logic [CFG_W-1:0] rows, input logic en);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_ROW_COUNT;
		cfg_wdata <= rows;
		@(negedge clk);
		cfg_idx   <= REG_LOOP_EN;
		cfg_wdata <= {(CFG_W-1)'($urandom_range(0, 63)), en};
		@(negedge clk);
		cfg_we    <= 1'b0;
		seq_rows  = rows;
		wrap_on   = en;
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle);

	// Result checker: every output beat against the oldest owed position.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (next_pos_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected beat: valid %0d row %0d repeat %0d",
						out_data.position_valid, out_data.next_row, out_data.next_repeat);
			end else begin
				due = next_pos_q.pop_front();
				if (out_data.position_valid !== due.position_valid ||
					out_data.next_row !== due.next_row ||
					out_data.next_repeat !== due.next_repeat) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: want valid %0d row %0d repeat %0d, got %0d %0d %0d",
							due.position_valid, due.next_row, due.next_repeat,
							out_data.position_valid, out_data.next_row, out_data.next_repeat);
				end
			end
		end
	end

	initial begin
		in_t  it;
		out_t want;
		out_t pos;
		int   pick;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = REG_ROW_COUNT;
		cfg_wdata   = '0;
		send_idle   = 34;
		recv_idle   = 80;
		fault_count = 0;
		seq_rows    = '0;
		wrap_on     = 1'b0;
		song_rows   = '{default: '0};
		wipe_jumps();
		ph_row      = 0;
		ph_rep      = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk.
		for (int s = 0; s < PLAN_N; s++) begin
			if (plan[s][0] == STEP_CFG) begin
				settle();
				write_regs(CFG_W'(plan[s][1]), plan[s][2][0]);
			end else begin
				it.mode                = MODE_W'(plan[s][1]);
				it.entry_index         = IDX_W'(plan[s][2]);
				it.entry_repeats       = REP_W'(plan[s][3]);
				it.entry_loop_back     = LB_W'(plan[s][4]);
				it.entry_loop_count    = LC_W'(plan[s][5]);
				it.entry_loop_infinite = plan[s][6][0];
				it.current_row         = IDX_W'(plan[s][7]);
				it.current_repeat      = REP_W'(plan[s][8]);
				want.position_valid    = plan[s][10][0];
				want.next_row          = IDX_W'(plan[s][11]);
				want.next_repeat       = REP_W'(plan[s][12]);
				play_beat(it, plan[s][9] != 0, want, pos);
			end
		end

		// Fill the whole table so no advance ever lands on an unwritten row.
		for (int r = 0; r < MAX_ROWS; r++) begin
			it = shaped_load();
			it.entry_index = IDX_W'(r);
			play_beat(it, 1'b0, '0, pos);
		end

		// Random phases: mostly the song played from its own playhead, plus
		// reloads, counter clears and noise.
		for (int seg = 0; seg < SEG_N; seg++) begin
			settle();
			write_regs(seg_rows[seg], seg_wrap[seg]);
			send_idle = (seg < 3) ? 34 : (seg < 6) ? 80 : 0;
			recv_idle = (seg < 3) ? 80 : (seg < 6) ? 34 : 0;
			live_rows = (int'(seg_rows[seg]) > MAX_ROWS) ? MAX_ROWS : int'(seg_rows[seg]);
			ph_row = 0;
			ph_rep = 0;
			for (int n = 0; n < SEG_BEATS; n++) begin
				pick = $urandom_range(0, 99);
				it = noise_item();
				if (pick < 60) begin
					it.mode           = MODE_ADV;
					it.current_row    = IDX_W'(ph_row);
					it.current_repeat = REP_W'(ph_rep);
				end else if (pick < 75)
					it = shaped_load();
				else if (pick < 85)
					it.mode = MODE_ADV;
				else if (pick < 90)
					it.mode = MODE_CLEAR;
				else if (pick < 94)
					it.mode = MODE_NONE;
				else
					it.mode = MODE_LOAD;
				play_beat(it, 1'b0, '0, pos);
				if (pick < 60) begin
					if (pos.position_valid) begin
						ph_row = int'(pos.next_row);
						ph_rep = int'(pos.next_repeat);
					end else begin
						// song over or off the end: restart, now and then mid-song
						ph_row = ($urandom_range(0, 3) == 0 && live_rows > 0)
							? int'($urandom_range(0, live_rows - 1)) : 0;
						ph_rep = 0;
					end
				end
			end
		end

		settle();
		// tail: catch any stray beat after the last owed one
		repeat (16) @(posedge clk);
		if (fault_count == 0 && next_pos_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule
